@@ hw/rtl/pait_pkg.sv @@
// ----------------------------------------------------------------------------
// pait_pkg
// Shared types and constants for the pending acknowledge identifier tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pait_pkg;

    // Default number of queue entries
    localparam int unsigned QUEUE_DEPTH_DEF = 32;

    // Identifier the counter takes after a flush and after it wraps
    localparam logic [15:0] ID_FIRST = 16'h0001;
    // Connack code that means accepted
    localparam logic [7:0]  CONNACK_OK = 8'h00;

    // Request opcodes
    localparam logic [1:0] OP_CONNACK = 2'd0;
    localparam logic [1:0] OP_SEND    = 2'd1;
    localparam logic [1:0] OP_ACK     = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] ack_id;
        logic [7:0]  connack_code;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [15:0] assigned_id;
        logic [1:0]  error_code;
        logic [5:0]  pending_count;
    } t_rsp;

endpackage

`default_nettype wire

@@ hw/rtl/pait_ram.sv @@
// ----------------------------------------------------------------------------
// pait_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pait_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/pending_ack_id_tracker_top.sv @@
// ----------------------------------------------------------------------------
// pending_ack_id_tracker_top
// Ring queue of message identifiers that still wait for an acknowledgement.
// ----------------------------------------------------------------------------
// Connack, send and unused opcodes, and an acknowledge on an empty queue,
// finish in the cycle the request is taken and the response appears in the
// next cycle. An acknowledge on a non-empty queue walks the queue from the
// head through the identifier RAM, one entry per cycle with reads issued one
// entry ahead, until it finds a match or has visited every entry; the
// response is registered when the walk ends. Entries that do not match are
// written back at the tail as they pass, so a miss leaves the queue in its
// original order. A new request is taken while the walk is not running and
// the response register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_ack_id_tracker_top #(
    parameter int unsigned QUEUE_DEPTH = pait_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire pait_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire logic           i_rsp_ready,
    output pait_pkg::t_rsp      o_rsp
);

    import pait_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] OCC_FULL = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state        r_state,     n_state;
    logic [PW-1:0] r_head,      n_head;
    logic [PW-1:0] r_tail,      n_tail;
    logic [CW-1:0] r_occ,       n_occ;
    logic [15:0]   r_next_id,   n_next_id;
    logic [PW-1:0] r_rd_ptr,    n_rd_ptr;
    logic [CW-1:0] r_cmp_left,  n_cmp_left;
    logic [15:0]   r_ack_id,    n_ack_id;
    logic          r_rsp_valid, n_rsp_valid;
    t_rsp          r_rsp,       n_rsp;

    logic          req_fire;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    pait_ram #(
        .WIDTH (16),
        .DEPTH (QUEUE_DEPTH)
    ) u_ids (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take a request only between walks, with room in the response register
    assign o_req_ready = (r_state == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign req_fire    = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Queue control: decode, walk, write back
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_next_id   = r_next_id;
        n_rd_ptr    = r_rd_ptr;
        n_cmp_left  = r_cmp_left;
        n_ack_id    = r_ack_id;
        n_rsp_valid = r_rsp_valid;
        n_rsp       = r_rsp;
        ram_we      = 1'b0;
        ram_waddr   = r_tail;
        ram_wdata   = r_next_id;
        ram_raddr   = (r_state == S_WALK) ? r_rd_ptr : r_head;

        // Drop the response once taken
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_rsp.accepted    = 1'b0;
                    n_rsp.assigned_id = '0;
                    n_rsp.error_code  = ERR_NONE;
                    n_rsp_valid       = 1'b1;
                    case (i_req.opcode)
                        OP_CONNACK: begin
                            if (i_req.connack_code == CONNACK_OK) begin
                                n_head         = r_tail;
                                n_occ          = '0;
                                n_next_id      = ID_FIRST;
                                n_rsp.accepted = 1'b1;
                            end
                        end
                        OP_SEND: begin
                            n_rsp.assigned_id = r_next_id;
                            if (r_occ != OCC_FULL) begin
                                ram_we         = 1'b1;
                                n_tail         = ring_next(r_tail);
                                n_occ          = r_occ + 1'b1;
                                n_rsp.accepted = 1'b1;
                            end else begin
                                n_rsp.error_code = ERR_FULL;
                            end
                            n_next_id = (r_next_id == 16'hFFFF) ? ID_FIRST
                                                                : r_next_id + 1'b1;
                        end
                        OP_ACK: begin
                            if (r_occ == '0) begin
                                n_rsp.error_code = ERR_EMPTY;
                            end else begin
                                // Head read is in flight; start the walk
                                n_rsp_valid = 1'b0;
                                n_ack_id    = i_req.ack_id;
                                n_rd_ptr    = ring_next(r_head);
                                n_cmp_left  = r_occ;
                                n_state     = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_rsp.pending_count = 6'(n_occ);
                end
            end
            S_WALK: begin
                // Read one entry ahead while comparing the current one
                n_rd_ptr = ring_next(r_rd_ptr);
                n_head   = ring_next(r_head);
                if (ram_rdata == r_ack_id) begin
                    // Remove the match and finish
                    n_occ               = r_occ - 1'b1;
                    n_rsp.accepted      = 1'b1;
                    n_rsp.assigned_id   = '0;
                    n_rsp.error_code    = ERR_NONE;
                    n_rsp.pending_count = 6'(r_occ - 1'b1);
                    n_rsp_valid         = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    // Rotate the entry to the tail
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    n_tail     = ring_next(r_tail);
                    n_cmp_left = r_cmp_left - 1'b1;
                    if (r_cmp_left == CW'(1)) begin
                        n_rsp.accepted      = 1'b0;
                        n_rsp.assigned_id   = '0;
                        n_rsp.error_code    = ERR_NONE;
                        n_rsp.pending_count = 6'(r_occ);
                        n_rsp_valid         = 1'b1;
                        n_state             = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_next_id   <= '0;
            r_rd_ptr    <= '0;
            r_cmp_left  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_next_id   <= n_next_id;
            r_rd_ptr    <= n_rd_ptr;
            r_cmp_left  <= n_cmp_left;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ack_id <= n_ack_id;
        r_rsp    <= n_rsp;
    end

endmodule

`default_nettype wire

@@ test/pending_ack_id_tracker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pending_ack_id_tracker_top_tb
// Self-checking bench for the pending acknowledge identifier tracker.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel with random gaps, and responses
// are drained with random stalls. Every accepted request updates a local copy
// of the identifier queue and counter, and the response it should cause is
// queued and compared field by field with what the block returns. A short
// table of hand-picked requests comes first, then random fill and drain
// phases that push the queue to full and back to empty.
// ----------------------------------------------------------------------------

module pending_ack_id_tracker_top_tb;

    import pait_pkg::*;

    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef struct {
        t_req req;
        bit   fixed;
        t_rsp rsp;
    } t_dir_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_req req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    t_rsp rsp;

    // Local copy of the tracker state
    logic [15:0] id_queue[$];
    logic [15:0] id_counter = 16'h0000;

    // Responses still owed by the block, oldest first
    t_rsp outcome_q[$];

    bit          quiet      = 1'b0;
    int unsigned cycles     = 0;
    int unsigned mismatches = 0;
    int unsigned n_req      = 0;
    int unsigned n_rsp      = 0;
    int unsigned n_hit      = 0;
    int unsigned n_full     = 0;
    int unsigned n_empty    = 0;
    int unsigned n_flush    = 0;

    // Hand-picked requests; a fixed row carries its response typed in
    t_dir_row dir_table [22] = '{
        '{'{OP_ACK,     16'h0000, 8'h00}, 1'b1, '{1'b0, 16'h0000, ERR_EMPTY, 6'd0}},
        '{'{OP_ACK,     16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 16'h0000, ERR_EMPTY, 6'd0}},
        '{'{OP_SEND,    16'h0000, 8'h00}, 1'b1, '{1'b1, 16'h0000, ERR_NONE,  6'd1}},
        '{'{OP_SEND,    16'hFFFF, 8'hFF}, 1'b1, '{1'b1, 16'h0001, ERR_NONE,  6'd2}},
        '{'{OP_UNUSED,  16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 16'h0000, ERR_NONE,  6'd2}},
        '{'{OP_CONNACK, 16'h0000, 8'hFF}, 1'b1, '{1'b0, 16'h0000, ERR_NONE,  6'd2}},
        '{'{OP_CONNACK, 16'hFFFF, 8'h01}, 1'b1, '{1'b0, 16'h0000, ERR_NONE,  6'd2}},
        '{'{OP_ACK,     16'hFFFF, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h0001, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h0000, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h0000, 8'h80}, 1'b1, '{1'b0, 16'h0000, ERR_EMPTY, 6'd0}},
        '{'{OP_CONNACK, 16'h0000, 8'h00}, 1'b1, '{1'b1, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_SEND,    16'h0000, 8'h00}, 1'b1, '{1'b1, 16'h0001, ERR_NONE,  6'd1}},
        '{'{OP_SEND,    16'h1234, 8'h55}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_SEND,    16'h0000, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_SEND,    16'h8000, 8'hAA}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h0003, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'hAAAA, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h5555, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_ACK,     16'h0002, 8'h00}, 1'b0, '{1'b0, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_CONNACK, 16'hFFFF, 8'h00}, 1'b1, '{1'b1, 16'h0000, ERR_NONE,  6'd0}},
        '{'{OP_UNUSED,  16'h0000, 8'h00}, 1'b1, '{1'b0, 16'h0000, ERR_NONE,  6'd0}}
    };

    pending_ack_id_tracker_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
    end

    // Advance the local tracker by one request and return its response
    function automatic void apply_request(input t_req r, output t_rsp p);
        int hit;
        p   = '0;
        hit = -1;
        case (r.opcode)
            OP_CONNACK: begin
                if (r.connack_code == CONNACK_OK) begin
                    id_queue.delete();
                    id_counter = ID_FIRST;
                    p.accepted = 1'b1;
                    n_flush++;
                end
            end
            OP_SEND: begin
                p.assigned_id = id_counter;
                if (id_queue.size() < QUEUE_DEPTH_DEF) begin
                    id_queue.push_back(id_counter);
                    p.accepted = 1'b1;
                end else begin
                    p.error_code = ERR_FULL;
                    n_full++;
                end
                // wrap skips zero
                id_counter = id_counter + 16'd1;
                if (id_counter == 16'h0000) begin
                    id_counter = ID_FIRST;
                end
            end
            OP_ACK: begin
                if (id_queue.size() == 0) begin
                    p.error_code = ERR_EMPTY;
                    n_empty++;
                end else begin
                    for (int k = 0; k < id_queue.size() && hit < 0; k++) begin
                        if (id_queue[k] == r.ack_id) begin
                            hit = k;
                        end
                    end
                    // entries ahead of the match rotate to the tail; a miss keeps order
                    if (hit >= 0) begin
                        for (int k = 0; k < hit; k++) begin
                            id_queue.push_back(id_queue[k]);
                        end
                        repeat (hit + 1) void'(id_queue.pop_front());
                        p.accepted = 1'b1;
                        n_hit++;
                    end
                end
            end
            default: begin
            end
        endcase
        p.pending_count = 6'(id_queue.size());
    endfunction

    // Present one request after a random gap and hold it until taken
    task automatic issue(input t_req r, input bit fixed, input t_rsp fixed_rsp);
        int unsigned gap;
        t_rsp        pred;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        apply_request(r, pred);
        outcome_q.push_back(fixed ? fixed_rsp : pred);
        n_req++;
    endtask

    // Drop valid and hold off until every owed response has come back
    task automatic wait_idle();
        req_valid <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        mismatches++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Response side: random stall before each response, none in quiet stretches
    initial begin
        int unsigned stall;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready && rst_n));
        end
    end

    // Check each response against the oldest owed one
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n && rsp_valid && rsp_ready) begin
            n_rsp++;
            if (outcome_q.size() == 0) begin
                mismatches++;
                $error("response with no request waiting");
            end else begin
                want = outcome_q.pop_front();
                if (rsp.accepted != want.accepted)
                    note_mismatch("accepted", want.accepted, rsp.accepted);
                if (rsp.assigned_id != want.assigned_id)
                    note_mismatch("assigned_id", want.assigned_id, rsp.assigned_id);
                if (rsp.error_code != want.error_code)
                    note_mismatch("error_code", want.error_code, rsp.error_code);
                if (rsp.pending_count != want.pending_count)
                    note_mismatch("pending_count", want.pending_count, rsp.pending_count);
            end
        end
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_req        r;
        int unsigned done;
        int unsigned sel;
        int unsigned pick;
        int unsigned seg_left;
        bit          fill;
        done     = 0;
        seg_left = 0;
        fill     = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the table
        foreach (dir_table[i]) begin
            issue(dir_table[i].req, dir_table[i].fixed, dir_table[i].rsp);
        end
        wait_idle();

        // Random phases: fill pushes toward a full queue, drain favors acks
        while (done < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(30, 70);
                fill     = $urandom_range(0, 1);
                quiet    = ($urandom_range(0, 4) == 0);
            end
            seg_left--;
            r.ack_id       = 16'($urandom());
            r.connack_code = 8'($urandom());
            sel            = $urandom_range(0, 99);
            if (sel < (fill ? 75 : 25)) begin
                r.opcode = OP_SEND;
            end else if (sel < 92) begin
                r.opcode = OP_ACK;
                if (id_queue.size() != 0 && $urandom_range(0, 3) != 0) begin
                    r.ack_id = id_queue[$urandom_range(0, id_queue.size() - 1)];
                end
            end else begin
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    r.opcode = OP_UNUSED;
                end else begin
                    r.opcode = OP_CONNACK;
                    if (!fill && pick == 3) begin
                        r.connack_code = CONNACK_OK;
                    end else if (r.connack_code == CONNACK_OK) begin
                        r.connack_code = 8'h01;
                    end
                end
            end
            issue(r, 1'b0, '0);
            if (r.opcode != OP_UNUSED) begin
                done++;
            end
        end
        quiet = 1'b0;
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d responses to %0d requests: %0d acks matched, %0d empty acks,",
                 n_rsp, n_req, n_hit, n_empty);
        $display("%0d sends on a full queue and %0d flushes over fill and drain phases.",
                 n_full, n_flush);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
